[rtl/core/tip_pkg.sv]
// ---------------------------------------------------------------------------
// tip_pkg
// Shared types, codes and character constants of the integer field parser.
// ---------------------------------------------------------------------------
package tip_pkg;

  // Result status codes
  localparam logic [1:0] ST_CONVERTED  = 2'd0;
  localparam logic [1:0] ST_MATCH_FAIL = 2'd1;
  localparam logic [1:0] ST_INPUT_FAIL = 2'd2;

  // Register indexes on the configuration port
  localparam logic REG_HEX_MODE    = 1'b0;
  localparam logic REG_FIELD_WIDTH = 1'b1;
  localparam int   CfgAddrWidth    = 3;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic {
    PH_SKIP,
    PH_DIGITS
  } phase_t;

  // What one character does to the field
  typedef enum logic [2:0] {
    ACT_NONE,        // blank while skipping
    ACT_SIGN_HOLD,   // sign taken, field goes on
    ACT_SIGN_END,    // sign taken, width reached
    ACT_DIGIT_HOLD,  // digit taken, field goes on
    ACT_DIGIT_END,   // digit taken, width reached
    ACT_STOP,        // field ends, character not taken
    ACT_EOI_FAIL     // end of input before any usable character
  } act_t;

  typedef struct packed {
    logic       hex_mode;
    logic [7:0] field_width;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value_bits;
    logic        char_consumed;
  } res_t;

endpackage

[rtl/core/tip_in_if.sv]
// ---------------------------------------------------------------------------
// tip_in_if
// Character request channel: one byte or an end-of-input mark per request.
// ---------------------------------------------------------------------------
interface tip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

[rtl/core/tip_out_if.sv]
// ---------------------------------------------------------------------------
// tip_out_if
// Field result channel: status, value and whether the character was taken.
// ---------------------------------------------------------------------------
interface tip_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] value_bits;
  logic        char_consumed;

  modport source (output valid, output status, output value_bits,
                  output char_consumed, input ready);
  modport sink   (input valid, input status, input value_bits,
                  input char_consumed, output ready);
endinterface

[rtl/core/tip_cfg_regs.sv]
// ---------------------------------------------------------------------------
// tip_cfg_regs
// APB register file holding the number base and the field width.
// ---------------------------------------------------------------------------
module tip_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tip_pkg::CfgAddrWidth-1:0]  paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output tip_pkg::cfg_t                     cfg
);
  import tip_pkg::*;

  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  // Write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hex_mode    <= 1'b0;
      cfg.field_width <= 8'd0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_HEX_MODE:    cfg.hex_mode    <= pwdata[0];
        REG_FIELD_WIDTH: cfg.field_width <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_HEX_MODE:    prdata = {31'd0, cfg.hex_mode};
      REG_FIELD_WIDTH: prdata = {24'd0, cfg.field_width};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

[rtl/core/tip_field_core.sv]
// ---------------------------------------------------------------------------
// tip_field_core
// Field state registers and the per-character decode and accumulate logic.
// ---------------------------------------------------------------------------
module tip_field_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic [7:0]     ch,
  input  logic           end_of_input,
  input  tip_pkg::cfg_t  cfg,
  output logic           emit,
  output tip_pkg::res_t  res
);
  import tip_pkg::*;

  phase_t      phase, phase_next;
  logic [31:0] accum, accum_next;
  logic        minus_seen, minus_seen_next;
  logic [7:0]  chars_taken, chars_taken_next;
  logic        any_digit, any_digit_next;

  act_t        act;
  logic        is_blank;
  logic        is_sign;
  logic        dig_ok;
  logic [3:0]  dig_val;
  logic [7:0]  taken_inc;
  logic        full_now;
  logic        full_inc;
  logic [31:0] accum_step;
  logic [31:0] fin_accum;
  logic        fin_any;

  // Classify the character
  always_comb begin
    is_blank = ch inside {CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR};
    is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
    dig_ok   = 1'b0;
    dig_val  = 4'd0;
    if (ch inside {[CH_ZERO:CH_NINE]}) begin
      dig_ok  = 1'b1;
      dig_val = 4'(ch - CH_ZERO);
    end else if (ch inside {[CH_LO_A:CH_LO_F]}) begin
      dig_ok  = cfg.hex_mode;
      dig_val = 4'(ch - CH_LO_A + 8'd10);
    end else if (ch inside {[CH_UP_A:CH_UP_F]}) begin
      dig_ok  = cfg.hex_mode;
      dig_val = 4'(ch - CH_UP_A + 8'd10);
    end
  end

  // Width bookkeeping; the count saturates at its top
  assign taken_inc = (chars_taken == 8'hFF) ? chars_taken : chars_taken + 8'd1;
  assign full_now  = (cfg.field_width != 8'd0) && (chars_taken >= cfg.field_width);
  assign full_inc  = (cfg.field_width != 8'd0) && (taken_inc >= cfg.field_width);

  // Multiply-add: times 16 is a shift, times 10 is two shifts and an add
  assign accum_step = (cfg.hex_mode ? {accum[27:0], 4'd0}
                                    : ({accum[28:0], 3'd0} + {accum[30:0], 1'b0}))
                      + {28'd0, dig_val};

  // Decide what this character does
  always_comb begin
    act = ACT_NONE;
    if (phase == PH_SKIP) begin
      if (end_of_input) begin
        act = ACT_EOI_FAIL;
      end else if (is_blank) begin
        act = ACT_NONE;
      end else if (is_sign) begin
        act = full_inc ? ACT_SIGN_END : ACT_SIGN_HOLD;
      end else if (dig_ok) begin
        act = full_inc ? ACT_DIGIT_END : ACT_DIGIT_HOLD;
      end else begin
        act = ACT_STOP;
      end
    end else begin
      if (full_now || end_of_input || !dig_ok) begin
        act = ACT_STOP;
      end else begin
        act = full_inc ? ACT_DIGIT_END : ACT_DIGIT_HOLD;
      end
    end
  end

  // Next state
  always_comb begin
    phase_next       = phase;
    accum_next       = accum;
    minus_seen_next  = minus_seen;
    chars_taken_next = chars_taken;
    any_digit_next   = any_digit;
    case (act)
      ACT_NONE: ;
      ACT_SIGN_HOLD: begin
        phase_next       = PH_DIGITS;
        minus_seen_next  = (ch == CH_MINUS);
        chars_taken_next = taken_inc;
      end
      ACT_DIGIT_HOLD: begin
        phase_next       = PH_DIGITS;
        accum_next       = accum_step;
        any_digit_next   = 1'b1;
        chars_taken_next = taken_inc;
      end
      ACT_SIGN_END, ACT_DIGIT_END, ACT_STOP, ACT_EOI_FAIL: begin
        phase_next       = PH_SKIP;
        accum_next       = 32'd0;
        minus_seen_next  = 1'b0;
        chars_taken_next = 8'd0;
        any_digit_next   = 1'b0;
      end
      default: ;
    endcase
  end

  // Result
  assign fin_accum = (act == ACT_DIGIT_END) ? accum_step : accum;
  assign fin_any   = (act == ACT_DIGIT_END) || any_digit;

  always_comb begin
    emit              = 1'b0;
    res.status        = ST_CONVERTED;
    res.value_bits    = 32'd0;
    res.char_consumed = 1'b0;
    case (act)
      ACT_EOI_FAIL: begin
        emit       = 1'b1;
        res.status = ST_INPUT_FAIL;
      end
      ACT_SIGN_END, ACT_DIGIT_END, ACT_STOP: begin
        emit              = 1'b1;
        res.char_consumed = (act != ACT_STOP);
        if (fin_any) begin
          res.status     = ST_CONVERTED;
          res.value_bits = minus_seen ? (32'd0 - fin_accum) : fin_accum;
        end else begin
          res.status = ST_MATCH_FAIL;
        end
      end
      default: ;
    endcase
  end

  // Hold the field state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SKIP;
      accum       <= 32'd0;
      minus_seen  <= 1'b0;
      chars_taken <= 8'd0;
      any_digit   <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      accum       <= accum_next;
      minus_seen  <= minus_seen_next;
      chars_taken <= chars_taken_next;
      any_digit   <= any_digit_next;
    end
  end

  // While skipping, nothing of a field is left over
  a_skip_clean: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP |-> chars_taken == 8'd0 && !any_digit && !minus_seen
                         && accum == 32'd0)
    else $error("field state not clear while skipping");

  // Every result leaves the parser skipping
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    step && emit |=> phase == PH_SKIP)
    else $error("field not cleared after result");

  // An input failure never takes the character
  a_eoi_fail: assert property (@(posedge clk) disable iff (rst)
    emit && res.status == ST_INPUT_FAIL |-> !res.char_consumed && phase == PH_SKIP)
    else $error("bad input failure result");

  // A match or input failure carries a zero value
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    emit && res.status != ST_CONVERTED |-> res.value_bits == 32'd0)
    else $error("failure with nonzero value");

endmodule

[rtl/core/tip_out_reg.sv]
// ---------------------------------------------------------------------------
// tip_out_reg
// Result register driving the result channel.
// ---------------------------------------------------------------------------
module tip_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  tip_pkg::res_t    res,
  output logic             free,
  tip_out_if.source        fields
);
  import tip_pkg::*;

  logic valid;
  res_t hold;

  assign free = !valid || fields.ready;

  // Load a new result or drop the delivered one
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (fields.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= res;
    end
  end

  assign fields.valid         = valid;
  assign fields.status        = hold.status;
  assign fields.value_bits    = hold.value_bits;
  assign fields.char_consumed = hold.char_consumed;

  // A load only happens into a free register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("result overwritten before delivery");

endmodule

[rtl/core/text_integer_field_parser_unit.sv]
// ---------------------------------------------------------------------------
// text_integer_field_parser_unit
// Parses one integer field at a time from a character stream.
// ---------------------------------------------------------------------------
//  Channel   Dir  Handshake      Carries
//  chars     in   valid/ready    ch[7:0], end_of_input
//  fields    out  valid/ready    status[1:0], value_bits[31:0], char_consumed
//  apb       in   psel/penable   hex_mode (0x0), field_width (0x4)
//
//  One character per cycle sustained while the result side is free; a request
//  is held in the input register and its result, if any, is loaded into the
//  result register as it advances. The multiply-add on the accumulator sets the cycle time.
//  Reset (rst, synchronous) clears the field state, both registers and the
//  configuration. A stalled result holds the input register; characters
//  that produce no result still advance only when the result side is free.
// ---------------------------------------------------------------------------
module text_integer_field_parser_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tip_pkg::CfgAddrWidth-1:0]  paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  tip_in_if.sink                            chars,
  tip_out_if.source                         fields
);
  import tip_pkg::*;

  cfg_t       cfg;
  logic       in_valid;
  logic [7:0] in_ch;
  logic       in_eoi;
  logic       out_free;
  logic       advance;
  logic       emit;
  res_t       res;

  tip_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance the held request when the result side can take its outcome
  assign advance     = in_valid && out_free;
  assign chars.ready = !in_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      in_ch  <= chars.ch;
      in_eoi <= chars.end_of_input;
    end
  end

  tip_field_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .ch           (in_ch),
    .end_of_input (in_eoi),
    .cfg          (cfg),
    .emit         (emit),
    .res          (res)
  );

  tip_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (advance && emit),
    .res    (res),
    .free   (out_free),
    .fields (fields)
  );

  // A held request is never lost while the result side is stalled
  a_hold_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_free |=> in_valid && $stable(in_ch) && $stable(in_eoi))
    else $error("held request changed while stalled");

endmodule
